// ===== src/assert_macros.svh =====
// Assertion helpers used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/pca_pkg.sv =====
package pca_pkg;

  // Command codes.
  localparam logic CMD_FREE  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_FIRST_FREE = 1'b0;
  localparam logic REG_TOP        = 1'b1;

  // Register reset values.
  localparam logic [31:0] FIRST_FREE_RESET = 32'h8000_0000;
  localparam logic [31:0] TOP_RESET        = 32'h8800_0000;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_t;

endpackage

// ===== src/pca_ram.sv =====
module pca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; the read word holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/per_cpu_page_allocator.sv =====
// Per-CPU page allocator: one LIFO free list per CPU, links kept in a single-port-read RAM.
// Input channel (in_valid/in_stall) carries one word: cmd, cpu_id, page_addr.
//   cmd = free pushes page_addr on the list of cpu_id; cmd = alloc pops that list, or
//   steals the head of the lowest-numbered other CPU whose list is not empty.
// Output channel (out_valid/out_stall) returns one word per input word, in order:
//   granted_addr, status (ok, empty, bad free) and stolen.
// Steps: a free or an alloc that finds no page is done in S_EXEC; an alloc that finds a
//   page starts the registered read of the next link from the link RAM in S_EXEC and
//   loads its result and the new list head in S_POP. Both wait in place while stalled.
// The result sits in an output register; a new word is taken in the cycle a result is
//   loaded, so a stalled receiver holds back at most the item behind the waiting result.
// Reset empties every list at once (list heads are flip-flops) and loads the register
//   reset values; the link RAM needs no clearing, so the block is ready right after reset.
// PAGE_BYTES must be a power of two. cpu_id values of NUM_CPUS or more wrap modulo NUM_CPUS.
// Registers (APB): byte 0 first_free_addr, byte 4 top_addr; write only while idle.
`include "assert_macros.svh"

module per_cpu_page_allocator #(
  parameter int NUM_CPUS   = 8,
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [2:0]  cpu_id,
  input  logic [31:0] page_addr,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] granted_addr,
  output logic [1:0]  status,
  output logic        stolen,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int IDX1_W     = $clog2(NUM_PAGES + 1);
  localparam int ADDR_W     = $clog2(NUM_PAGES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_W       = 33 - PAGE_SHIFT;
  localparam logic [32:0] RST_SUM =
      33'(pca_pkg::FIRST_FREE_RESET) + 33'(PAGE_BYTES - 1);
  localparam logic [PG_W-1:0] BASE_PG_RESET = RST_SUM[32:PAGE_SHIFT];

  // Configuration registers and the derived base page number.
  logic [31:0]     first_free_addr;
  logic [31:0]     top_addr;
  logic [PG_W-1:0] base_pg;
  logic            cfg_we;
  logic [32:0]     cfg_sum;

  // Latched input word.
  logic            cmd_q;
  logic [CPU_W-1:0] cpu_q;
  logic [31:0]     addr_q;

  // List heads: page index + 1, zero when empty.
  logic [IDX1_W-1:0] heads [NUM_CPUS];
  logic [NUM_CPUS-1:0] nonempty;

  pca_pkg::state_t state, state_next;

  logic [CPU_W-1:0] cpu_map [8];
  logic [CPU_W-1:0] victim;
  logic             pick_found;
  logic             pick_steal;
  logic [CPU_W-1:0] sel_cpu;
  logic [IDX1_W-1:0] sel_head;
  logic [CPU_W-1:0] victim_q;
  logic             steal_q;

  logic            accept;
  logic            slot_free;
  logic            done;
  logic [PG_W-1:0] idx_full;
  logic            bad_free;
  logic [PG_W-1:0] grant_pg;
  logic [32:0]     grant_full;

  // Link RAM and sequencer outputs.
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [IDX1_W-1:0] ram_rdata;
  logic              head_we;
  logic [CPU_W-1:0]  head_widx;
  logic [IDX1_W-1:0] head_wdata;
  logic [31:0]       res_granted;
  logic [1:0]        res_status;
  logic              res_stolen;

  // cpu_id reduced modulo NUM_CPUS through a constant table.
  for (genvar g = 0; g < 8; g++) begin : g_cpu_map
    assign cpu_map[g] = CPU_W'(g % NUM_CPUS);
  end

  for (genvar g = 0; g < NUM_CPUS; g++) begin : g_nonempty
    assign nonempty[g] = (heads[g] != '0);
  end

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sum = {1'b0, pwdata} + 33'(PAGE_BYTES - 1);

  always_comb begin
    unique case (paddr[2])
      pca_pkg::REG_FIRST_FREE: prdata = first_free_addr;
      pca_pkg::REG_TOP:        prdata = top_addr;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_free_addr <= pca_pkg::FIRST_FREE_RESET;
      top_addr        <= pca_pkg::TOP_RESET;
      base_pg         <= BASE_PG_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == pca_pkg::REG_FIRST_FREE) begin
        first_free_addr <= pwdata;
        base_pg         <= cfg_sum[32:PAGE_SHIFT];
      end else begin
        top_addr <= pwdata;
      end
    end
  end

  // Handshake: a word is taken when idle or in the cycle a result is loaded.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !((state == pca_pkg::S_IDLE) || done);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      cpu_q  <= cpu_map[cpu_id];
      addr_q <= page_addr;
    end
  end

  // Pick the list to pop: own list first, else the lowest other non-empty one.
  always_comb begin
    victim     = cpu_q;
    pick_found = nonempty[cpu_q];
    pick_steal = 1'b0;
    if (!nonempty[cpu_q]) begin
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
        if (CPU_W'(i) != cpu_q && nonempty[i]) begin
          victim     = CPU_W'(i);
          pick_found = 1'b1;
          pick_steal = 1'b1;
        end
      end
    end
  end

  assign sel_cpu  = (cmd_q == pca_pkg::CMD_FREE) ? cpu_q : victim;
  assign sel_head = heads[sel_cpu];

  // Free address check and page index relative to the base.
  assign idx_full = {1'b0, addr_q[31:PAGE_SHIFT]} - base_pg;
  assign bad_free = (addr_q[PAGE_SHIFT-1:0] != '0) || (addr_q < first_free_addr) ||
                    (addr_q >= top_addr) || (idx_full >= PG_W'(NUM_PAGES));

  // Granted address from the popped head index.
  assign grant_pg   = base_pg + PG_W'(IDX1_W'(heads[victim_q] - 1'b1));
  assign grant_full = {grant_pg, {PAGE_SHIFT{1'b0}}};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pca_pkg::S_IDLE: begin
        if (accept) begin
          state_next = pca_pkg::S_EXEC;
        end
      end
      pca_pkg::S_EXEC: begin
        if (cmd_q == pca_pkg::CMD_ALLOC && pick_found) begin
          state_next = pca_pkg::S_POP;
        end else if (done) begin
          state_next = accept ? pca_pkg::S_EXEC : pca_pkg::S_IDLE;
        end
      end
      pca_pkg::S_POP: begin
        if (done) begin
          state_next = accept ? pca_pkg::S_EXEC : pca_pkg::S_IDLE;
        end
      end
      default: state_next = pca_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: memory accesses, head updates and the result word.
  always_comb begin
    done        = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = ADDR_W'(idx_full);
    ram_raddr   = ADDR_W'(sel_head - 1'b1);
    head_we     = 1'b0;
    head_widx   = sel_cpu;
    head_wdata  = IDX1_W'(idx_full + PG_W'(1));
    res_granted = '0;
    res_status  = pca_pkg::ST_OK;
    res_stolen  = 1'b0;
    unique case (state)
      pca_pkg::S_IDLE: begin
      end
      pca_pkg::S_EXEC: begin
        if (cmd_q == pca_pkg::CMD_FREE) begin
          done = slot_free;
          if (bad_free) begin
            res_status = pca_pkg::ST_BADFREE;
          end else begin
            ram_we  = slot_free;
            head_we = slot_free;
          end
        end else if (pick_found) begin
          ram_re = 1'b1;
        end else begin
          done       = slot_free;
          res_status = pca_pkg::ST_EMPTY;
        end
      end
      pca_pkg::S_POP: begin
        done        = slot_free;
        head_we     = slot_free;
        head_widx   = victim_q;
        head_wdata  = ram_rdata;
        res_granted = grant_full[31:0];
        res_stolen  = steal_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pca_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      victim_q <= victim;
      steal_q  <= pick_steal;
    end
  end

  // List heads, all empty after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        heads[i] <= '0;
      end
    end else if (head_we) begin
      heads[head_widx] <= head_wdata;
    end
  end

  pca_ram #(
    .WIDTH(IDX1_W),
    .DEPTH(NUM_PAGES)
  ) u_links (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(sel_head),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      granted_addr <= res_granted;
      status       <= res_status;
      stolen       <= res_stolen;
    end
  end

  `ASSERT_NOW(a_fail_no_addr, clk, rst, out_valid && status != pca_pkg::ST_OK, granted_addr == '0 && !stolen)
  `ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == pca_pkg::S_EXEC)
  `ASSERT_NOW(a_pop_nonempty, clk, rst, state == pca_pkg::S_POP, nonempty[victim_q])
  `ASSERT_NOW(a_link_write_free, clk, rst, ram_we, state == pca_pkg::S_EXEC && cmd_q == pca_pkg::CMD_FREE && !bad_free)
  `ASSERT_NEXT(a_pop_follows_read, clk, rst, ram_re, state == pca_pkg::S_POP)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int N_CPUS = 8;
  localparam int N_PAGES = 32768;
  localparam int PAGE_SZ = 4096;
  localparam int STUCK_LIMIT = 2000;

  // One page request word and the reply word it should produce.
  typedef struct {
    logic        op;
    logic [2:0]  cpu;
    logic [31:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
    logic        stolen;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = pca_pkg::CMD_FREE;
  logic [2:0]  cpu_id = 3'd0;
  logic [31:0] page_addr = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] granted_addr;
  logic [1:0]  status;
  logic        stolen;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Requests waiting to be sent and replies waiting to arrive.
  page_req_t req_q[$];
  grant_t    grant_q[$];

  // Shadow of the allocator: list heads, links and both registers.
  logic [15:0] head_tab[N_CPUS];
  logic [15:0] link_tab[N_PAGES];
  logic [31:0] cfg_first = pca_pkg::FIRST_FREE_RESET;
  logic [31:0] cfg_top = pca_pkg::TOP_RESET;

  int  err_cnt = 0;
  int  seen_cnt = 0;
  int  grant_cnt = 0;
  int  steal_cnt = 0;
  int  empty_cnt = 0;
  int  bad_cnt = 0;
  int  fresh_idx = 64;
  int  stuck_cnt = 0;
  bit  calm = 1'b0;
  int  gap_left = 0;
  int  in_idle_pct = 10;
  int  stall_left = 0;
  int  out_idle_pct = 10;
  int  hold_left = 0;

  per_cpu_page_allocator #(
    .NUM_CPUS(N_CPUS),
    .NUM_PAGES(N_PAGES),
    .PAGE_BYTES(PAGE_SZ)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .cpu_id(cpu_id),
    .page_addr(page_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .granted_addr(granted_addr),
    .status(status),
    .stolen(stolen),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lowest managed page address: first_free rounded up to a page boundary.
  function automatic longint unsigned page_base();
    longint unsigned f;
    f = 64'(cfg_first);
    return ((f + PAGE_SZ - 1) / PAGE_SZ) * PAGE_SZ;
  endfunction

  // Apply one request to the shadow lists and queue the reply it should get.
  function automatic void model_page_op(logic op, logic [2:0] cpu_raw, logic [31:0] addr);
    grant_t          g;
    logic [2:0]      cpu;
    int              c;
    longint unsigned base;
    longint unsigned a;
    longint unsigned idx;
    logic [15:0]     pick;
    g.addr = 32'd0;
    g.status = pca_pkg::ST_OK;
    g.stolen = 1'b0;
    cpu = 3'(cpu_raw % N_CPUS);
    base = page_base();
    a = 64'(addr);
    if (op == pca_pkg::CMD_FREE) begin
      if ((a % PAGE_SZ) != 0 || addr < cfg_first || addr >= cfg_top) begin
        g.status = pca_pkg::ST_BADFREE;
      end else begin
        idx = (a - base) / PAGE_SZ;
        if (idx >= N_PAGES) begin
          g.status = pca_pkg::ST_BADFREE;
        end else begin
          link_tab[15'(idx)] = head_tab[cpu];
          head_tab[cpu] = 16'(idx + 1);
        end
      end
    end else begin
      // Own list first, then the lowest-numbered other CPU with a page.
      pick = 16'd0;
      if (head_tab[cpu] != 16'd0) begin
        pick = head_tab[cpu];
        head_tab[cpu] = link_tab[15'(pick - 16'd1)];
      end
      for (c = 0; c < N_CPUS && pick == 16'd0; c++) begin
        if (3'(c) != cpu && head_tab[3'(c)] != 16'd0) begin
          pick = head_tab[3'(c)];
          head_tab[3'(c)] = link_tab[15'(pick - 16'd1)];
          g.stolen = 1'b1;
        end
      end
      if (pick == 16'd0) begin
        g.status = pca_pkg::ST_EMPTY;
      end else begin
        idx = 64'(pick);
        g.addr = 32'(base + (idx - 1) * PAGE_SZ);
      end
    end
    if (g.status == pca_pkg::ST_EMPTY) empty_cnt++;
    if (g.status == pca_pkg::ST_BADFREE) bad_cnt++;
    if (op == pca_pkg::CMD_ALLOC && g.status == pca_pkg::ST_OK) grant_cnt++;
    if (g.stolen) steal_cnt++;
    grant_q.push_back(g);
  endfunction

  // Random request for the current register setting. Good frees use pages
  // that are not listed yet, so the lists stay free of loops.
  function automatic page_req_t make_req(int free_pct);
    page_req_t       r;
    longint unsigned base;
    longint unsigned span;
    longint unsigned top;
    r.op = pca_pkg::CMD_ALLOC;
    r.cpu = 3'($urandom_range(0, 7));
    r.addr = $urandom;
    if ($urandom_range(0, 99) >= free_pct) return r;
    r.op = pca_pkg::CMD_FREE;
    // Frees land mostly on a few CPUs so that the others have to steal.
    if ($urandom_range(0, 3) != 0) r.cpu = 3'($urandom_range(0, 2));
    base = page_base();
    top = 64'(cfg_top);
    span = (top > base) ? (top - base + PAGE_SZ - 1) / PAGE_SZ : 64'd0;
    if (span > N_PAGES) span = 64'(N_PAGES);
    if ($urandom_range(0, 9) < 7 && fresh_idx < span) begin
      r.addr = 32'(base + fresh_idx * PAGE_SZ);
      fresh_idx += $urandom_range(1, 3);
    end else begin
      case ($urandom_range(0, 4))
        0: r.addr = 32'(base + $urandom_range(0, 255) * PAGE_SZ + $urandom_range(1, PAGE_SZ - 1));
        1: if (cfg_first != 32'd0) r.addr = $urandom_range(cfg_first - 1, 0);
        2: r.addr = cfg_top;
        3: r.addr = $urandom_range(32'hFFFF_FFFF, cfg_top);
        default: r.addr = 32'(base + (N_PAGES + $urandom_range(0, 15)) * PAGE_SZ);
      endcase
    end
    return r;
  endfunction

  task automatic add_req(logic op, logic [2:0] cpu, logic [31:0] addr);
    page_req_t r;
    r.op = op;
    r.cpu = cpu;
    r.addr = addr;
    req_q.push_back(r);
  endtask

  // Wait until every request is sent and every reply has come back.
  task automatic wait_drained();
    while (req_q.size() != 0 || grant_q.size() != 0 || in_valid) @(negedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == pca_pkg::REG_FIRST_FREE) cfg_first = val;
    else cfg_top = val;
  endtask

  task automatic run_random(int count);
    int i;
    @(negedge clk);
    // Alternate fill and drain stretches so that lists run empty and steals happen.
    for (i = 0; i < count; i++) req_q.push_back(make_req(((i / 40) % 2 == 0) ? 75 : 30));
    wait_drained();
  endtask

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Driver: offers the oldest pending word and holds it while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        model_page_op(cmd, cpu_id, page_addr);
        void'(req_q.pop_front());
      end
      if ($urandom_range(0, 127) == 0) in_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
      if (in_valid && in_stall) begin
        // Stalled: the word stays as it is.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0 && !calm && $urandom_range(0, 99) < in_idle_pct) begin
        gap_left = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        in_valid <= 1'b1;
        cmd <= req_q[0].op;
        cpu_id <= req_q[0].cpu;
        page_addr <= req_q[0].addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each reply word and drives the receiver stall.
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          err_cnt++;
          $display("%0t: reply with nothing expected, granted_addr %h status %0d",
                   $time, granted_addr, status);
        end else begin
          want = grant_q.pop_front();
          if (granted_addr !== want.addr) report_field("granted_addr", want.addr, granted_addr);
          if (status !== want.status) begin
            report_field("status", 32'(want.status), 32'(status));
          end
          if (stolen !== want.stolen) begin
            report_field("stolen", 32'(want.stolen), 32'(stolen));
          end
        end
        seen_cnt++;
        // Long hold-off so that the block backs up and stalls its input.
        if (!calm && (seen_cnt == 300 || seen_cnt == 1000)) hold_left = 80;
      end
      if ($urandom_range(0, 127) == 0) out_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no word accepted on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  initial begin
    int saved_idx;
    foreach (head_tab[i]) head_tab[i] = 16'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset register values.
    add_req(pca_pkg::CMD_ALLOC, 3'd0, 32'h0000_0000);
    add_req(pca_pkg::CMD_FREE, 3'd0, 32'h8000_0000);
    add_req(pca_pkg::CMD_FREE, 3'd0, 32'h87FF_F000);
    add_req(pca_pkg::CMD_FREE, 3'd7, 32'h8000_1000);
    add_req(pca_pkg::CMD_FREE, 3'd0, 32'h7FFF_F000);
    add_req(pca_pkg::CMD_FREE, 3'd1, 32'h8800_0000);
    add_req(pca_pkg::CMD_FREE, 3'd2, 32'h8000_0800);
    add_req(pca_pkg::CMD_FREE, 3'd3, 32'hFFFF_FFFF);
    add_req(pca_pkg::CMD_FREE, 3'd4, 32'h0000_0000);
    add_req(pca_pkg::CMD_ALLOC, 3'd0, 32'hFFFF_FFFF);
    add_req(pca_pkg::CMD_ALLOC, 3'd0, 32'h0000_0000);
    add_req(pca_pkg::CMD_ALLOC, 3'd0, 32'h5555_5555);
    add_req(pca_pkg::CMD_ALLOC, 3'd3, 32'hAAAA_AAAA);
    // Double free builds a loop on CPU 2; freeing the page to CPU 5 breaks it.
    add_req(pca_pkg::CMD_FREE, 3'd2, 32'h8000_2000);
    add_req(pca_pkg::CMD_FREE, 3'd2, 32'h8000_2000);
    add_req(pca_pkg::CMD_ALLOC, 3'd2, 32'h0000_0000);
    add_req(pca_pkg::CMD_ALLOC, 3'd2, 32'h0000_0000);
    add_req(pca_pkg::CMD_FREE, 3'd5, 32'h8000_2000);
    add_req(pca_pkg::CMD_ALLOC, 3'd2, 32'h0000_0000);
    add_req(pca_pkg::CMD_ALLOC, 3'd6, 32'h0000_0000);
    // Steal order: the lowest-numbered CPU with a page wins.
    add_req(pca_pkg::CMD_FREE, 3'd6, 32'h8000_3000);
    add_req(pca_pkg::CMD_FREE, 3'd4, 32'h8000_4000);
    add_req(pca_pkg::CMD_ALLOC, 3'd7, 32'h0000_0000);
    add_req(pca_pkg::CMD_ALLOC, 3'd7, 32'h0000_0000);
    add_req(pca_pkg::CMD_ALLOC, 3'd1, 32'h0000_0000);
    wait_drained();

    run_random(800);

    // Unaligned first address and the widest top; listed pages get a new base.
    write_reg(pca_pkg::REG_FIRST_FREE, 32'h0000_0123);
    write_reg(pca_pkg::REG_TOP, 32'hFFFF_FFFF);
    run_random(550);

    // Base wraps past the address space and nothing can be freed.
    write_reg(pca_pkg::REG_FIRST_FREE, 32'hFFFF_FFFF);
    write_reg(pca_pkg::REG_TOP, 32'h0000_0000);
    run_random(60);

    // Sixteen-page window at address zero.
    write_reg(pca_pkg::REG_FIRST_FREE, 32'h0000_0000);
    write_reg(pca_pkg::REG_TOP, 32'h0001_0000);
    saved_idx = fresh_idx;
    fresh_idx = 0;
    run_random(80);
    fresh_idx = saved_idx;

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    write_reg(pca_pkg::REG_FIRST_FREE, 32'h4000_0000);
    write_reg(pca_pkg::REG_TOP, 32'hC000_0000);
    run_random(450);

    repeat (10) @(negedge clk);
    $display("%0d words checked: %0d pages granted (%0d stolen), %0d empty, %0d bad frees",
             seen_cnt, grant_cnt, steal_cnt, empty_cnt, bad_cnt);
    $display("Register settings: reset, unaligned base, wrapped base, zero top, 16-page window");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== per_cpu_page_allocator.f =====
+incdir+src
src/pca_pkg.sv
src/pca_ram.sv
src/per_cpu_page_allocator.sv
tb/tb_top.sv
